// File: hdl/drm_pkg.sv
// ----------------------------------------------------------------------------
// drm_pkg
// shared types and constants of the dose rate anomaly monitor
// ----------------------------------------------------------------------------
package drm_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOSE_VOLUME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAILY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP      = 3'd6;
  localparam int CFG_DATA_W = 32;

  // configuration reset values
  localparam logic [11:0] RST_DOSE_VOLUME = 12'd50;
  localparam logic [15:0] RST_DAILY_LIMIT = 16'd1000;
  localparam logic [15:0] RST_ALPHA       = 16'd6554;
  localparam logic [7:0]  RST_YELLOW      = 8'd150;
  localparam logic [7:0]  RST_RED         = 8'd250;
  localparam logic [31:0] RST_WINDOW      = 32'd86400;
  localparam logic [7:0]  RST_WARMUP      = 8'd5;

  // arithmetic constants
  localparam logic [19:0] RATE_SCALE  = 20'd921600;  // 3600 s/h times 256 (q.8)
  localparam logic [6:0]  DEV_SCALE   = 7'd100;
  localparam logic [31:0] DEV_MIN_AVG = 32'd3;       // 3/256 ml/h in q.8, about 0.012 ml/h
  localparam logic [15:0] ALPHA_ONE   = 16'd32768;
  localparam logic [47:0] ROUND_HALF  = 48'd16384;
  localparam logic [7:0]  WARM_MAX    = 8'd255;

  // shared divider
  localparam int DIV_W     = 40;
  localparam int DIV_CNT_W = 6;

  // result codes
  localparam logic [1:0] ALERT_NONE   = 2'd0;
  localparam logic [1:0] ALERT_YELLOW = 2'd1;
  localparam logic [1:0] ALERT_RED    = 2'd2;
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DAILY    = 2'd1;
  localparam logic [1:0] ERR_RED      = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_seconds;
  } drm_in_t;

  typedef struct packed {
    logic [15:0]       cycle_number;
    logic [31:0]       interval_seconds;
    logic [31:0]       rate_q8;
    logic signed [7:0] deviation_percent_sigma;
    logic [1:0]        alarm_level;
    logic              warmup_flag;
    logic              red_alert_flag;
    logic [15:0]       window_volume_ml;
    logic [1:0]        error_code;
  } drm_out_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic prep;
    logic rate_zero;
    logic div_start;
    logic div_sel_dev;
    logic rate_take;
    logic avg_run;
    logic dev_prep;
    logic dev_zero;
    logic dev_take;
    logic scan_run;
    logic emit;
  } drm_cmd_t;

  typedef struct packed {
    logic req_clear;
    logic interval_zero;
    logic div_done;
    logic avg_done;
    logic dev_need;
    logic scan_done;
    logic out_free;
  } drm_sts_t;

endpackage

// File: hdl/dose_rate_anomaly_monitor.sv
// ----------------------------------------------------------------------------
// dose_rate_anomaly_monitor
// rate, averages, deviation, alert and rolling window volume per dose event
// ----------------------------------------------------------------------------
// a clear word passes from accept through the decode and emit states to the output register
// a dose word passes through the rate divide, averaging, deviation divide and ring scan
//   states before emit; the ring scan reads every filled ring entry
// both divides share the 40-step divider, and the ring scan makes one read a cycle
// one word at a time; the next is taken once the result sits in the output register
// reset is synchronous, active low: averages, counts and ring pointers go to zero,
//   configuration to its defaults; the stamp ring itself is not cleared
module dose_rate_anomaly_monitor #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [drm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // event words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  drm_pkg::drm_in_t                in_data,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output drm_pkg::drm_out_t               out_data
);
  import drm_pkg::*;

  // command and status between the sequencer and the datapath
  drm_cmd_t cmd;
  drm_sts_t sts;

  // sequencer: walks each dose word through divide, average, divide, scan; a clear word goes straight to emit
  drm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: config registers, history state, divider, ring memory, output register
  drm_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/drm_div.sv
// ----------------------------------------------------------------------------
// drm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module drm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [drm_pkg::DIV_W-1:0]  dividend,
  input  logic [31:0]                divisor,
  output logic                       busy,
  output logic                       done,
  output logic [drm_pkg::DIV_W-1:0]  quotient
);
  import drm_pkg::*;

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [33:0]          trial;

  assign trial = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[DIV_W-1]};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/drm_dp.sv
// ----------------------------------------------------------------------------
// drm_dp
// datapath: configuration, averages, divider, stamp ring and result register
// ----------------------------------------------------------------------------
module drm_dp #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [drm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [drm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  drm_pkg::drm_in_t                    in_data,
  input  drm_pkg::drm_cmd_t                   cmd,
  output drm_pkg::drm_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output drm_pkg::drm_out_t                   out_data
);
  import drm_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);

  // configuration
  logic [11:0] dose_r;
  logic [15:0] limit_r;
  logic [15:0] alpha_r;
  logic [7:0]  yellow_r;
  logic [7:0]  red_r;
  logic [31:0] window_r;
  logic [7:0]  warm_ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dose_r    <= RST_DOSE_VOLUME;
      limit_r   <= RST_DAILY_LIMIT;
      alpha_r   <= RST_ALPHA;
      yellow_r  <= RST_YELLOW;
      red_r     <= RST_RED;
      window_r  <= RST_WINDOW;
      warm_ev_r <= RST_WARMUP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOSE_VOLUME: dose_r    <= cfg_wdata[11:0];
        CFG_DAILY_LIMIT: limit_r   <= cfg_wdata[15:0];
        CFG_ALPHA:       alpha_r   <= cfg_wdata[15:0];
        CFG_YELLOW:      yellow_r  <= cfg_wdata[7:0];
        CFG_RED:         red_r     <= cfg_wdata[7:0];
        CFG_WINDOW:      window_r  <= cfg_wdata;
        CFG_WARMUP:      warm_ev_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // history state
  logic [31:0]   last_r, avg_rate_r, avg_int_r, avg_dev_r;
  logic [7:0]    warm_r;
  logic [15:0]   cyc_r;
  logic [AW-1:0] head_r;
  logic [FW-1:0] fill_r;

  // per-word working registers
  drm_in_t          in_r;
  logic [15:0]      cyc_out_r;
  logic [31:0]      interval_r, rate_r, cutoff_r, rate_num_r;
  logic             wz_r;
  logic [2:0]       step_r;
  logic [47:0]      acc_r;
  logic             dev_neg_r;
  logic [DIV_W-1:0] dev_num_r;
  logic signed [7:0] dev_r;
  logic [FW-1:0]    scan_idx_r;
  logic             pv_r;
  logic [15:0]      vol_r;
  logic [31:0]      ring_q_r;
  logic [31:0]      ring_mem [HISTORY_DEPTH];

  // prep values
  logic [31:0] interval_nxt;
  assign interval_nxt = (last_r != 32'd0 && in_r.now_seconds > last_r) ?
                        in_r.now_seconds - last_r : 32'd0;

  // averaging: one shared multiplier, two steps per average
  logic        mix;
  logic [15:0] a_eff, b_eff, mul_a;
  logic [31:0] diff_abs, xsel, avgsel, mul_b;
  logic [47:0] prod, mix_sum;
  logic [31:0] mix_res;

  assign mix      = (interval_r != 32'd0) && !wz_r;
  assign a_eff    = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign b_eff    = ALPHA_ONE - a_eff;
  assign diff_abs = (rate_r >= avg_rate_r) ? rate_r - avg_rate_r : avg_rate_r - rate_r;

  always_comb begin
    case (step_r[2:1])
      2'd0:    begin xsel = diff_abs;   avgsel = avg_dev_r;  end
      2'd1:    begin xsel = rate_r;     avgsel = avg_rate_r; end
      default: begin xsel = interval_r; avgsel = avg_int_r;  end
    endcase
  end

  assign mul_a   = step_r[0] ? b_eff : a_eff;
  assign mul_b   = step_r[0] ? avgsel : xsel;
  assign prod    = 48'(mul_a) * 48'(mul_b);
  assign mix_sum = acc_r + prod + ROUND_HALF;
  assign mix_res = mix_sum[46:15];

  // deviation numerator
  logic [38:0] dev_prod;
  assign dev_prod = 39'(diff_abs) * 39'(DEV_SCALE);

  // divider
  logic             div_busy, div_done;
  logic [DIV_W-1:0] div_quo;

  drm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel_dev ? dev_num_r : {{(DIV_W-32){1'b0}}, rate_num_r}),
    .divisor  (cmd.div_sel_dev ? avg_dev_r : interval_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic q_big;
  assign q_big = |div_quo[DIV_W-1:7];

  // ring scan
  logic        scan_rd;
  logic [16:0] vol_sum;
  assign scan_rd = cmd.scan_run && (scan_idx_r < fill_r);
  assign vol_sum = {1'b0, vol_r} + 17'(dose_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) ring_mem[head_r] <= in_r.now_seconds;
    ring_q_r <= ring_mem[scan_idx_r[AW-1:0]];
  end

  // result fields
  logic [8:0]  dev_ext;
  logic [7:0]  dev_mag;
  logic        warm_ok;
  logic [1:0]  alert;
  logic        red_flag;
  logic [1:0]  err;
  logic        out_valid_r;
  drm_out_t    out_r, res;

  assign dev_ext = dev_r[7] ? -{dev_r[7], dev_r} : {dev_r[7], dev_r};
  assign dev_mag = dev_ext[7:0];
  assign warm_ok = warm_r >= warm_ev_r;

  always_comb begin
    alert = ALERT_NONE;
    if (warm_ok) begin
      if (dev_mag >= red_r)         alert = ALERT_RED;
      else if (dev_mag >= yellow_r) alert = ALERT_YELLOW;
    end
    red_flag = (alert == ALERT_RED) && (warm_r > warm_ev_r);
    if (vol_r >= limit_r) err = ERR_DAILY;
    else if (red_flag)    err = ERR_RED;
    else                  err = ERR_NONE;
    res.cycle_number            = cyc_out_r;
    res.interval_seconds        = interval_r;
    res.rate_q8                 = rate_r;
    res.deviation_percent_sigma = dev_r;
    res.alarm_level             = alert;
    res.warmup_flag             = warm_r <= warm_ev_r;
    res.red_alert_flag          = red_flag;
    res.window_volume_ml        = vol_r;
    res.error_code              = err;
    if (in_r.req_type) res = '0;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.prep) begin
      interval_r <= interval_nxt;
      cyc_out_r  <= cyc_r;
      wz_r       <= (warm_r == 8'd0);
      rate_num_r <= 32'(dose_r) * 32'(RATE_SCALE);
      cutoff_r   <= (in_r.now_seconds > window_r) ? in_r.now_seconds - window_r : 32'd0;
      vol_r      <= '0;
    end
    if (cmd.rate_zero) rate_r <= '0;
    if (cmd.rate_take) rate_r <= div_quo[31:0];
    if (cmd.avg_run && !step_r[0]) acc_r <= prod;
    if (cmd.dev_prep) begin
      dev_neg_r <= rate_r < avg_rate_r;
      dev_num_r <= DIV_W'(dev_prod);
    end
    if (cmd.dev_zero) dev_r <= '0;
    if (cmd.dev_take) begin
      if (dev_neg_r) dev_r <= (div_quo >= DIV_W'(128)) ? -8'sd128 : -$signed(div_quo[7:0]);
      else           dev_r <= q_big ? 8'sd127 : $signed(div_quo[7:0]);
    end
    if (pv_r && ring_q_r >= cutoff_r)
      vol_r <= vol_sum[16] ? 16'hFFFF : vol_sum[15:0];
    if (cmd.emit) out_r <= res;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      avg_rate_r  <= '0;
      avg_int_r   <= '0;
      avg_dev_r   <= '0;
      warm_r      <= '0;
      cyc_r       <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      step_r      <= '0;
      scan_idx_r  <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        last_r     <= '0;
        avg_rate_r <= '0;
        avg_int_r  <= '0;
        avg_dev_r  <= '0;
        warm_r     <= '0;
        head_r     <= '0;
        fill_r     <= '0;
      end
      if (cmd.prep) begin
        last_r     <= in_r.now_seconds;
        warm_r     <= (warm_r == WARM_MAX) ? WARM_MAX : warm_r + 1'b1;
        cyc_r      <= cyc_r + 1'b1;
        head_r     <= (head_r == AW'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
        if (fill_r < FW'(HISTORY_DEPTH)) fill_r <= fill_r + 1'b1;
        step_r     <= '0;
        scan_idx_r <= '0;
        pv_r       <= 1'b0;
      end
      if (cmd.avg_run) begin
        if (!mix) begin
          if (interval_r != 32'd0) begin
            avg_rate_r <= rate_r;
            avg_int_r  <= interval_r;
            avg_dev_r  <= '0;
          end else begin
            avg_int_r  <= '0;
          end
        end else begin
          if (step_r != 3'd5) step_r <= step_r + 1'b1;
          if (step_r == 3'd1) avg_dev_r  <= mix_res;
          if (step_r == 3'd3) avg_rate_r <= mix_res;
          if (step_r == 3'd5) avg_int_r  <= mix_res;
        end
      end
      if (cmd.scan_run) begin
        pv_r <= scan_rd;
        if (scan_rd) scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.emit)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.req_clear     = in_r.req_type;
    sts.interval_zero = (interval_r == 32'd0);
    sts.div_done      = div_done;
    sts.avg_done      = !mix || (step_r == 3'd5);
    sts.dev_need      = warm_ok && (avg_dev_r >= DEV_MIN_AVG);
    sts.scan_done     = (scan_idx_r == fill_r) && !pv_r;
    sts.out_free      = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HISTORY_DEPTH))
    else $error("ring fill above depth");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_avg_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 3'd5)
    else $error("averaging step out of range");

endmodule

// File: hdl/drm_ctrl.sv
// ----------------------------------------------------------------------------
// drm_ctrl
// sequencer for one word: rate divide, averaging, deviation divide, ring scan
// ----------------------------------------------------------------------------
module drm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  drm_pkg::drm_sts_t sts,
  output drm_pkg::drm_cmd_t cmd
);
  import drm_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DECODE  = 4'd1;
  localparam logic [3:0] ST_RSTART  = 4'd2;
  localparam logic [3:0] ST_RWAIT   = 4'd3;
  localparam logic [3:0] ST_AVG     = 4'd4;
  localparam logic [3:0] ST_DEVPREP = 4'd5;
  localparam logic [3:0] ST_DSTART  = 4'd6;
  localparam logic [3:0] ST_DWAIT   = 4'd7;
  localparam logic [3:0] ST_SCAN    = 4'd8;
  localparam logic [3:0] ST_EMIT    = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.req_clear) begin
          cmd.clear = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = ST_RSTART;
        end
      end
      ST_RSTART: begin
        if (sts.interval_zero) begin
          cmd.rate_zero = 1'b1;
          state_nxt     = ST_AVG;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_RWAIT;
        end
      end
      ST_RWAIT: begin
        if (sts.div_done) begin
          cmd.rate_take = 1'b1;
          state_nxt     = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.avg_run = 1'b1;
        if (sts.avg_done) state_nxt = ST_DEVPREP;
      end
      ST_DEVPREP: begin
        cmd.dev_prep = 1'b1;
        state_nxt    = ST_DSTART;
      end
      ST_DSTART: begin
        if (sts.dev_need) begin
          cmd.div_start   = 1'b1;
          cmd.div_sel_dev = 1'b1;
          state_nxt       = ST_DWAIT;
        end else begin
          cmd.dev_zero = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          cmd.dev_take = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
